### design/srep_pkg.sv
`timescale 1ns / 1ps

package srep_pkg;

  localparam int TABLE_ENTRIES   = 41;
  localparam int MAX_PATTERN_LEN = 4;
  localparam int WIN_DEPTH       = MAX_PATTERN_LEN + 1;
  localparam int EMOJI_MAX       = 6;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int ENTRY_W   = $clog2(TABLE_ENTRIES);
  localparam int EMO_IDX_W = $clog2(EMOJI_MAX);
  localparam int ELEN_W    = $clog2(EMOJI_MAX + 1);
  localparam int Q_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } msg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } emo_t;

  typedef struct packed {
    logic               is_emoji;
    logic [ENTRY_W-1:0] entry;
    logic [7:0]         lit;
    logic               last;
  } token_t;

  // patterns are left-justified, first byte in the top byte lane
  localparam logic [8*MAX_PATTERN_LEN-1:0] PAT [TABLE_ENTRIES] = '{
    32'h3E3A2D28, 32'h3E3A2800, 32'h4F3A2D29, 32'h4F3A2900,
    32'h3A272D28, 32'h3A272800, 32'h3C2F3300, 32'h3A2D2900,
    32'h3B2D2900, 32'h3A2D4400, 32'h3A2D5000, 32'h3A2D7000,
    32'h3A2D2800, 32'h3A2D2F00, 32'h3A2D7C00, 32'h3A2D4F00,
    32'h3A2D6F00, 32'h3A2D2A00, 32'h3A2D5300, 32'h3A2D7300,
    32'h3A2D5800, 32'h3A5E2900, 32'h422D2900, 32'h3A290000,
    32'h3B290000, 32'h3A440000, 32'h3A500000, 32'h3A700000,
    32'h3A280000, 32'h3A2F0000, 32'h3A7C0000, 32'h3A4F0000,
    32'h3A6F0000, 32'h3A2A0000, 32'h3A530000, 32'h3A730000,
    32'h3A580000, 32'h42290000, 32'h58440000, 32'h78440000,
    32'h3C330000
  };

  localparam logic [CNT_W-1:0] PLEN [TABLE_ENTRIES] = '{
    3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2
  };

  localparam logic [8*EMOJI_MAX-1:0] EMO [TABLE_ENTRIES] = '{
    48'hF09F98A00000, 48'hF09F98A00000, 48'hF09F98870000, 48'hF09F98870000,
    48'hF09F98A20000, 48'hF09F98A20000, 48'hF09F92940000, 48'hF09F98800000,
    48'hF09F98890000, 48'hF09F98830000, 48'hF09F989B0000, 48'hF09F989B0000,
    48'hF09F989E0000, 48'hF09F98950000, 48'hF09F98900000, 48'hF09F98AE0000,
    48'hF09F98AE0000, 48'hF09F98980000, 48'hF09F98960000, 48'hF09F98960000,
    48'hF09FA4900000, 48'hF09F988F0000, 48'hF09F988E0000, 48'hF09F98800000,
    48'hF09F98890000, 48'hF09F98830000, 48'hF09F989B0000, 48'hF09F989B0000,
    48'hF09F989E0000, 48'hF09F98950000, 48'hF09F98900000, 48'hF09F98AE0000,
    48'hF09F98AE0000, 48'hF09F98980000, 48'hF09F98960000, 48'hF09F98960000,
    48'hF09FA4900000, 48'hF09F988E0000, 48'hF09F98860000, 48'hF09F98860000,
    48'hE29DA4EFB88F
  };

  localparam logic [ELEN_W-1:0] ELEN [TABLE_ENTRIES] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd6
  };

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

### design/srep_front.sv
`timescale 1ns / 1ps

module srep_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  srep_pkg::msg_t        msg,
  output logic                  tok_valid,
  output srep_pkg::token_t      tok,
  input  logic                  tok_full
);

  logic [7:0]                 win      [srep_pkg::WIN_DEPTH];
  logic [7:0]                 win_next [srep_pkg::WIN_DEPTH];
  logic [srep_pkg::CNT_W-1:0] cnt, cnt_next, cnt_after, take;
  logic [7:0]                 prev, prev_next, a;
  logic                       start, start_next, drain, drain_next;
  logic                       need, fire, accept, boundary, m, ok, hit;
  logic [srep_pkg::ENTRY_W-1:0] hit_e;

  always_comb begin
    need     = (cnt == srep_pkg::CNT_W'(srep_pkg::WIN_DEPTH)) || (drain && cnt != '0);
    fire     = need && !tok_full;
    boundary = start || !srep_pkg::is_alnum(prev);
    hit      = 1'b0;
    hit_e    = '0;
    take     = srep_pkg::CNT_W'(1);
    m        = 1'b0;
    ok       = 1'b0;
    a        = '0;
    // scan backward so the earliest table entry wins
    for (int e = srep_pkg::TABLE_ENTRIES - 1; e >= 0; e--) begin
      m = boundary && (srep_pkg::PLEN[e] <= cnt);
      for (int i = 0; i < srep_pkg::MAX_PATTERN_LEN; i++) begin
        if (srep_pkg::CNT_W'(i) < srep_pkg::PLEN[e] &&
            win[i] != srep_pkg::PAT[e][8*(srep_pkg::MAX_PATTERN_LEN-i)-1 -: 8]) begin
          m = 1'b0;
        end
      end
      if (srep_pkg::PLEN[e] < cnt) begin
        a  = win[srep_pkg::PLEN[e][srep_pkg::WIN_IDX_W-1:0]];
        ok = !srep_pkg::is_alnum(a) &&
             !(srep_pkg::PLEN[e] <= srep_pkg::CNT_W'(2) &&
               (a == srep_pkg::CH_SLASH || a == srep_pkg::CH_BSLASH));
      end else begin
        ok = drain;
      end
      if (m && ok) begin
        hit   = 1'b1;
        hit_e = srep_pkg::ENTRY_W'(e);
        take  = srep_pkg::PLEN[e];
      end
    end

    cnt_after    = fire ? cnt - take : cnt;
    tok_valid    = fire;
    tok.is_emoji = hit;
    tok.entry    = hit_e;
    tok.lit      = win[0];
    tok.last     = drain && (cnt_after == '0);

    msg_stall = drain || ((cnt == srep_pkg::CNT_W'(srep_pkg::WIN_DEPTH)) && !fire);
    accept    = msg_valid && !msg_stall;

    win_next   = win;
    prev_next  = prev;
    start_next = start;
    drain_next = drain;
    if (fire) begin
      for (int t = 1; t <= srep_pkg::MAX_PATTERN_LEN; t++) begin
        if (take == srep_pkg::CNT_W'(t)) begin
          prev_next = win[t-1];
          for (int i = 0; i + t < srep_pkg::WIN_DEPTH; i++) begin
            win_next[i] = win[i+t];
          end
        end
      end
      start_next = 1'b0;
      if (tok.last) begin
        prev_next  = '0;
        start_next = 1'b1;
        drain_next = 1'b0;
      end
    end
    cnt_next = cnt_after;
    if (accept) begin
      win_next[cnt_after[srep_pkg::WIN_IDX_W-1:0]] = msg.in_byte;
      cnt_next = cnt_after + srep_pkg::CNT_W'(1);
      if (msg.in_last) begin
        drain_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      prev  <= '0;
      start <= 1'b1;
      drain <= 1'b0;
    end else begin
      cnt   <= cnt_next;
      prev  <= prev_next;
      start <= start_next;
      drain <= drain_next;
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

endmodule

### design/srep_fifo.sv
`timescale 1ns / 1ps

module srep_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srep_pkg::token_t din,
  output logic             full,
  output logic             valid,
  output srep_pkg::token_t dout,
  input  logic             pop
);

  srep_pkg::token_t             mem [srep_pkg::QUEUE_DEPTH];
  logic [srep_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [srep_pkg::Q_CNT_W-1:0] count;
  logic                         do_push, do_pop;

  assign full    = (count == srep_pkg::Q_CNT_W'(srep_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + srep_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + srep_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + srep_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - srep_pkg::Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

### design/srep_back.sv
`timescale 1ns / 1ps

module srep_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  input  srep_pkg::token_t tok_in,
  output logic             tok_pop,
  output logic             emo_valid,
  input  logic             emo_stall,
  output srep_pkg::emo_t   emo
);

  srep_pkg::token_t               tok_r;
  logic                           busy, advance, cur_final;
  logic [srep_pkg::EMO_IDX_W-1:0] idx;
  logic [8*srep_pkg::EMOJI_MAX-1:0] emo_word;
  logic [7:0]                     cur_byte;

  always_comb begin
    emo_word  = srep_pkg::EMO[tok_r.entry] << {idx, 3'b000};
    cur_byte  = tok_r.is_emoji ? emo_word[8*srep_pkg::EMOJI_MAX-1 -: 8] : tok_r.lit;
    cur_final = !tok_r.is_emoji ||
                (idx == srep_pkg::EMO_IDX_W'(srep_pkg::ELEN[tok_r.entry] - 1'b1));
    advance   = busy && (!emo_valid || !emo_stall);
    tok_pop   = tok_valid && (!busy || (advance && cur_final));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      emo_valid <= 1'b0;
    end else begin
      if (advance) begin
        emo_valid    <= 1'b1;
        emo.out_byte <= cur_byte;
        emo.out_last <= tok_r.last && cur_final;
        idx          <= cur_final ? '0 : idx + srep_pkg::EMO_IDX_W'(1);
      end else if (!emo_stall) begin
        emo_valid <= 1'b0;
      end
      if (tok_pop) begin
        tok_r <= tok_in;
        busy  <= 1'b1;
      end else if (advance && cur_final) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### design/smiley_to_emoji_replacer_unit.sv
`timescale 1ns / 1ps
// Channel | Handshake                   | Payload
// msg     | msg_valid / msg_stall (in)  | srep_pkg::msg_t  (in_byte, in_last)
// emo     | emo_valid / emo_stall (out) | srep_pkg::emo_t  (out_byte, out_last)
//
// Input takes one byte per cycle while the five-byte match window has room or
// resolves its head in that same cycle; the window head is matched against all
// pattern entries at once. After a last byte the window drains one head per
// cycle while the queue has room, and input stalls until it is empty.
// Output gives one byte per cycle unless stalled: 1 per plain byte, 4 or 6
// per emoji, so output stalls back up through a 4-entry queue into the window.
// Reset (rst, synchronous) empties window, queue and output register.

module smiley_to_emoji_replacer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           msg_valid,
  output logic           msg_stall,
  input  srep_pkg::msg_t msg,
  output logic           emo_valid,
  input  logic           emo_stall,
  output srep_pkg::emo_t emo
);

  srep_pkg::token_t f_tok, q_tok;
  logic             f_valid, q_full, q_valid, q_pop;

  srep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .tok_valid (f_valid),
    .tok       (f_tok),
    .tok_full  (q_full)
  );

  srep_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   (f_tok),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_tok),
    .pop   (q_pop)
  );

  srep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok_in    (q_tok),
    .tok_pop   (q_pop),
    .emo_valid (emo_valid),
    .emo_stall (emo_stall),
    .emo       (emo)
  );

endmodule

### design/srep_checker.sv
`timescale 1ns / 1ps

module srep_checker (
  input logic           clk,
  input logic           rst,
  input logic           msg_valid,
  input logic           msg_stall,
  input srep_pkg::msg_t msg,
  input logic           emo_valid,
  input logic           emo_stall,
  input srep_pkg::emo_t emo
);

  // hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    emo_valid && emo_stall |=> emo_valid && $stable(emo))
    else $error("stalled output transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !emo_valid)
    else $error("output valid right after reset");

  // drain the window after the last input byte
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && msg.in_last |=> msg_stall)
    else $error("input taken right after last byte");

endmodule

bind smiley_to_emoji_replacer_unit srep_checker u_srep_checker (.*);

### verif/emoji_stream_checker.sv
`timescale 1ns / 1ps

module emoji_stream_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           msg_valid,
  input  logic           msg_stall,
  input  srep_pkg::msg_t msg,
  input  logic           emo_valid,
  input  logic           emo_stall,
  input  srep_pkg::emo_t emo,
  output int             mismatches,
  output int             backlog,
  output int             bytes_checked,
  output int             smileys_replaced
);

  localparam int         SMILEY_COUNT   = 41;
  localparam int         WINDOW_BYTES   = 5;
  localparam logic [7:0] SLASH_CHAR     = 8'h2F;
  localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;

  srep_pkg::emo_t expected_text[$];
  logic [7:0]     window [WINDOW_BYTES];
  int             window_fill;
  logic [7:0]     prev_byte;
  logic           msg_start;

  function automatic logic alnum_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // patterns and glyphs are right-justified, first byte in the highest used lane
  function automatic void smiley_rom(input int idx, output logic [31:0] pat,
                                     output logic [47:0] glyph);
    pat   = '0;
    glyph = '0;
    case (idx)
      0:  begin pat = ">:-("; glyph = 'hF09F98A0; end
      1:  begin pat = ">:(";  glyph = 'hF09F98A0; end
      2:  begin pat = "O:-)"; glyph = 'hF09F9887; end
      3:  begin pat = "O:)";  glyph = 'hF09F9887; end
      4:  begin pat = ":'-("; glyph = 'hF09F98A2; end
      5:  begin pat = ":'(";  glyph = 'hF09F98A2; end
      6:  begin pat = "</3";  glyph = 'hF09F9294; end
      7:  begin pat = ":-)";  glyph = 'hF09F9880; end
      8:  begin pat = ";-)";  glyph = 'hF09F9889; end
      9:  begin pat = ":-D";  glyph = 'hF09F9883; end
      10: begin pat = ":-P";  glyph = 'hF09F989B; end
      11: begin pat = ":-p";  glyph = 'hF09F989B; end
      12: begin pat = ":-(";  glyph = 'hF09F989E; end
      13: begin pat = ":-/";  glyph = 'hF09F9895; end
      14: begin pat = ":-|";  glyph = 'hF09F9890; end
      15: begin pat = ":-O";  glyph = 'hF09F98AE; end
      16: begin pat = ":-o";  glyph = 'hF09F98AE; end
      17: begin pat = ":-*";  glyph = 'hF09F9898; end
      18: begin pat = ":-S";  glyph = 'hF09F9896; end
      19: begin pat = ":-s";  glyph = 'hF09F9896; end
      20: begin pat = ":-X";  glyph = 'hF09FA490; end
      21: begin pat = ":^)";  glyph = 'hF09F988F; end
      22: begin pat = "B-)";  glyph = 'hF09F988E; end
      23: begin pat = ":)";   glyph = 'hF09F9880; end
      24: begin pat = ";)";   glyph = 'hF09F9889; end
      25: begin pat = ":D";   glyph = 'hF09F9883; end
      26: begin pat = ":P";   glyph = 'hF09F989B; end
      27: begin pat = ":p";   glyph = 'hF09F989B; end
      28: begin pat = ":(";   glyph = 'hF09F989E; end
      29: begin pat = ":/";   glyph = 'hF09F9895; end
      30: begin pat = ":|";   glyph = 'hF09F9890; end
      31: begin pat = ":O";   glyph = 'hF09F98AE; end
      32: begin pat = ":o";   glyph = 'hF09F98AE; end
      33: begin pat = ":*";   glyph = 'hF09F9898; end
      34: begin pat = ":S";   glyph = 'hF09F9896; end
      35: begin pat = ":s";   glyph = 'hF09F9896; end
      36: begin pat = ":X";   glyph = 'hF09FA490; end
      37: begin pat = "B)";   glyph = 'hF09F988E; end
      38: begin pat = "XD";   glyph = 'hF09F9886; end
      39: begin pat = "xD";   glyph = 'hF09F9886; end
      40: begin pat = "<3";   glyph = 'hE29DA4EFB88F; end
      default: ;
    endcase
  endfunction

  task automatic expect_byte(input logic [7:0] b);
    srep_pkg::emo_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    expected_text.push_back(r);
  endtask

  task automatic resolve_head(input logic last);
    logic [31:0] pat;
    logic [47:0] glyph;
    logic [7:0]  after;
    logic        ok;
    int          plen, take, hit;
    take = 1;
    hit  = -1;
    if (msg_start || !alnum_char(prev_byte)) begin
      for (int e = 0; e < SMILEY_COUNT && hit < 0; e++) begin
        smiley_rom(e, pat, glyph);
        plen = 0;
        for (int k = 0; k < 4; k++) if (pat[8*k +: 8] != 8'h00) plen++;
        if (plen > window_fill) continue;
        ok = 1'b1;
        for (int k = 0; k < plen; k++)
          if (window[k] != pat[8*(plen-1-k) +: 8]) ok = 1'b0;
        if (!ok) continue;
        if (plen < window_fill) begin
          after = window[plen];
          ok = !alnum_char(after);
          if (plen <= 2 && (after == SLASH_CHAR || after == BACKSLASH_CHAR)) ok = 1'b0;
        end else begin
          ok = last;
        end
        if (ok) begin
          hit  = e;
          take = plen;
        end
      end
    end
    if (hit >= 0) begin
      smileys_replaced++;
      for (int k = (glyph[47:40] != 8'h00) ? 5 : 3; k >= 0; k--) expect_byte(glyph[8*k +: 8]);
    end else begin
      expect_byte(window[0]);
    end
    prev_byte = window[take-1];
    for (int k = 0; k + take < WINDOW_BYTES; k++) window[k] = window[k+take];
    window_fill -= take;
    msg_start = 1'b0;
  endtask

  task automatic accept_text_byte(input logic [7:0] b, input logic last);
    srep_pkg::emo_t tail;
    if (window_fill < WINDOW_BYTES) begin
      window[window_fill] = b;
      window_fill++;
    end
    while (window_fill == WINDOW_BYTES || (last && window_fill > 0)) resolve_head(last);
    if (last) begin
      tail = expected_text.pop_back();
      tail.out_last = 1'b1;
      expected_text.push_back(tail);
      window_fill = 0;
      prev_byte   = 8'h00;
      msg_start   = 1'b1;
    end
  endtask

  task automatic check_text_byte();
    srep_pkg::emo_t want;
    bytes_checked++;
    if (expected_text.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output at %0t: byte %h last %b", $time, emo.out_byte, emo.out_last);
    end else begin
      want = expected_text.pop_front();
      if (want.out_byte != emo.out_byte || want.out_last != emo.out_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected byte %h last %b, got byte %h last %b",
                   $time, want.out_byte, want.out_last, emo.out_byte, emo.out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_text.delete();
      window_fill      = 0;
      prev_byte        = 8'h00;
      msg_start        = 1'b1;
      mismatches       = 0;
      bytes_checked    = 0;
      smileys_replaced = 0;
    end else begin
      if (emo_valid && !emo_stall) check_text_byte();
      if (msg_valid && !msg_stall) accept_text_byte(msg.in_byte, msg.in_last);
    end
    backlog = expected_text.size();
  end

endmodule

### verif/tb_smiley_to_emoji_replacer_unit.sv
`timescale 1ns / 1ps

module tb_smiley_to_emoji_replacer_unit;

  localparam int ITEM_TARGET     = 375;
  localparam int PRESSURE_AT     = 150;
  localparam int PRESSURE_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           msg_valid = 1'b0;
  logic           msg_stall;
  srep_pkg::msg_t msg       = '0;
  logic           emo_valid;
  logic           emo_stall = 1'b0;
  srep_pkg::emo_t emo;

  int   mismatches, backlog, bytes_checked, smileys_replaced;
  int   items_sent    = 0;
  int   messages_sent = 0;
  int   cycles        = 0;
  int   stall_left    = 0;
  int   recv_mode     = 0;
  int   send_mode     = 0;
  logic pressure_done = 1'b0;

  logic [7:0] text_q[$];
  string      smileys, alnum_chars, punct_chars, face_chars;
  int         tok_pos[$], tok_len[$];

  smiley_to_emoji_replacer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .emo_valid (emo_valid),
    .emo_stall (emo_stall),
    .emo       (emo)
  );

  emoji_stream_checker text_check (
    .clk              (clk),
    .rst              (rst),
    .msg_valid        (msg_valid),
    .msg_stall        (msg_stall),
    .msg              (msg),
    .emo_valid        (emo_valid),
    .emo_stall        (emo_stall),
    .emo              (emo),
    .mismatches       (mismatches),
    .backlog          (backlog),
    .bytes_checked    (bytes_checked),
    .smileys_replaced (smileys_replaced)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles, backlog);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random hold-offs, calm stretches, and one long hold to back the block up
  always @(posedge clk) begin
    if (cycles % 64 == 0) recv_mode <= $urandom_range(0, 2);
    if (rst) begin
      emo_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      emo_stall  <= 1'b1;
    end else if (!pressure_done && items_sent >= PRESSURE_AT) begin
      pressure_done <= 1'b1;
      stall_left    <= PRESSURE_CYCLES - 1;
      emo_stall     <= 1'b1;
    end else if (recv_mode != 0 && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      emo_stall  <= 1'b1;
    end else begin
      emo_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    srep_pkg::msg_t item;
    int gap;
    gap = 0;
    if (send_mode != 0 && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.in_byte = b;
    item.in_last = l;
    msg_valid <= 1'b1;
    msg       <= item;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    items_sent++;
    if (items_sent % 40 == 0) send_mode = $urandom_range(0, 2);
  endtask

  task automatic send_message();
    for (int i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    messages_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_smiley();
    int k;
    k = $urandom_range(0, tok_pos.size() - 1);
    for (int i = 0; i < tok_len[k]; i++) text_q.push_back(smileys[tok_pos[k] + i]);
  endtask

  task automatic build_message();
    int pieces;
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_smiley();
        4, 5:       text_q.push_back(" ");
        6:          repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(alnum_chars));
        7:          text_q.push_back(pick_char(punct_chars));
        8:          text_q.push_back(8'($urandom_range(1, 255)));
        default:    repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(face_chars));
      endcase
    end
  endtask

  initial begin
    int start;
    smileys = ">:-( >:( O:-) O:) :'-( :'( </3 :-) ;-) :-D :-P :-p :-( :-/ :-| :-O :-o ";
    smileys = {smileys, ":-* :-S :-s :-X :^) B-) :) ;) :D :P :p :( :/ :| :O :o :* :S :s "};
    smileys = {smileys, ":X B) XD xD <3"};
    alnum_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    punct_chars = " .,!?/\\\t";
    face_chars  = ":;-()'<>/3DPpoOX^B*|Ssx\\";
    start = 0;
    for (int i = 0; i <= smileys.len(); i++) begin
      if (i == smileys.len() || smileys[i] == " ") begin
        if (i > start) begin
          tok_pos.push_back(start);
          tok_len.push_back(i - start);
        end
        start = i + 1;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_text(">:-(");
    send_message();
    add_text("x:):)/");
    send_message();
    add_text(":)a <3\\");
    send_message();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    add_text(":D");
    send_message();
    add_text(":");
    send_message();

    while (items_sent < ITEM_TARGET) begin
      build_message();
      send_message();
    end

    msg_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("sent %0d messages of %0d bytes in total; checked %0d output bytes",
             messages_sent, items_sent, bytes_checked);
    $display("%0d smileys replaced; one receiver hold of %0d cycles under full input",
             smileys_replaced, PRESSURE_CYCLES);
    if (mismatches == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", mismatches, backlog);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
